// ----- rtl/core/meter_frame_poll_and_parse_assert.svh -----
// Assertion macros for the meter poll and frame parser.
`ifndef METER_FRAME_POLL_AND_PARSE_ASSERT_SVH
`define METER_FRAME_POLL_AND_PARSE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MFPP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MFPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFPP_ASSERT_ALWAYS(lbl, cond, msg)
`define MFPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mfpp_pkg.sv -----
// Shared types, constants and helper functions of the meter poll and frame parser.
`default_nettype none
package mfpp_pkg;

  localparam int STORE_BYTES_DEF = 19;
  // counter width for emit index; covers stores up to 32 bytes
  localparam int CNT_W = 5;

  localparam logic [7:0] HDR_BYTE    = 8'hA5;
  localparam logic [7:0] FRAME_SIZE  = 8'h08;
  localparam logic [7:0] CMD_SET_PTR = 8'h41;
  localparam logic [7:0] ADDR_HIGH   = 8'h00;
  localparam logic [7:0] CMD_READ    = 8'h4E;
  localparam logic [7:0] ACK_BYTE    = 8'h06;

  localparam logic [7:0] POS_IDLE  = 8'd0;
  localparam logic [7:0] POS_ACK   = 8'd1;
  localparam logic [7:0] POS_LEN   = 8'd2;
  localparam logic [7:0] POS_DATA  = 8'd3;

  localparam logic [1:0] REG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_ADDR    = 2'd1;
  localparam logic [1:0] REG_LEN     = 2'd2;
  localparam logic [1:0] REG_REQ_SUM = 2'd3;

  localparam logic [7:0] PERIOD_RST  = 8'd3;
  localparam logic [7:0] ADDR_RST    = 8'd2;
  localparam logic [7:0] LEN_RST     = 8'd28;
  localparam logic [7:0] REQ_SUM_RST = 8'd90;

  localparam logic [2:0] REQ_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] period_ticks;
    logic [7:0] reg_addr;
    logic [7:0] read_len;
    logic [7:0] request_sum;
  } cfg_t;

  typedef struct packed {
    logic             accept;     // input transfer this cycle
    logic             load;       // load output register
    logic             sel_store;  // 1: sample store byte, 0: request byte
    logic [CNT_W-1:0] idx;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic req_go;    // accepted tick would send a request
    logic dump_go;   // accepted byte passes the checksum
    logic out_free;  // output register can take a byte
  } sts_t;

  function automatic logic is_skip(input logic [7:0] p);
    logic r;
    r = ((p >= 8'd4) && (p <= 8'd6)) || ((p >= 8'd11) && (p <= 8'd12)) ||
        ((p >= 8'd23) && (p <= 8'd26));
    return r;
  endfunction

  function automatic logic [7:0] req_byte(input logic [2:0] i, input cfg_t c);
    logic [7:0] r;
    case (i)
      3'd0:    r = HDR_BYTE;
      3'd1:    r = FRAME_SIZE;
      3'd2:    r = CMD_SET_PTR;
      3'd3:    r = ADDR_HIGH;
      3'd4:    r = c.reg_addr;
      3'd5:    r = CMD_READ;
      3'd6:    r = c.read_len;
      default: r = c.request_sum;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mfpp_cfg.sv -----
// Configuration register file with its APB-style access port.
`default_nettype none
module mfpp_cfg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output mfpp_pkg::cfg_t      cfg
);

  mfpp_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks <= mfpp_pkg::PERIOD_RST;
      cfg_r.reg_addr     <= mfpp_pkg::ADDR_RST;
      cfg_r.read_len     <= mfpp_pkg::LEN_RST;
      cfg_r.request_sum  <= mfpp_pkg::REQ_SUM_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        mfpp_pkg::REG_PERIOD:  cfg_r.period_ticks <= pwdata[7:0];
        mfpp_pkg::REG_ADDR:    cfg_r.reg_addr     <= pwdata[7:0];
        mfpp_pkg::REG_LEN:     cfg_r.read_len     <= pwdata[7:0];
        mfpp_pkg::REG_REQ_SUM: cfg_r.request_sum  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mfpp_pkg::REG_PERIOD:  prdata = {24'd0, cfg_r.period_ticks};
      mfpp_pkg::REG_ADDR:    prdata = {24'd0, cfg_r.reg_addr};
      mfpp_pkg::REG_LEN:     prdata = {24'd0, cfg_r.read_len};
      mfpp_pkg::REG_REQ_SUM: prdata = {24'd0, cfg_r.request_sum};
      default:               prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/mfpp_ctrl.sv -----
// Controller: accepts items and sequences the request and sample byte runs.
`default_nettype none
module mfpp_ctrl #(
  parameter int STORE_BYTES = mfpp_pkg::STORE_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mfpp_pkg::sts_t      sts,
  output mfpp_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REQ  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  localparam logic [mfpp_pkg::CNT_W-1:0] DUMP_LAST =
    mfpp_pkg::CNT_W'(STORE_BYTES - 1);
  localparam logic [mfpp_pkg::CNT_W-1:0] REQ_LAST =
    mfpp_pkg::CNT_W'(mfpp_pkg::REQ_LAST);

  logic [1:0]                 state_r, state_nxt;
  logic [mfpp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       run_last;

  assign in_ready = (state_r == ST_IDLE);
  assign run_last = (state_r == ST_DUMP) ? (cnt_r == DUMP_LAST) : (cnt_r == REQ_LAST);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.accept    = 1'b0;
    cmd.load      = 1'b0;
    cmd.sel_store = (state_r == ST_DUMP);
    cmd.idx       = cnt_r;
    cmd.last      = run_last;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        cnt_nxt    = '0;
        if (in_valid && sts.req_go) begin
          state_nxt = ST_REQ;
        end else if (in_valid && sts.dump_go) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_REQ, ST_DUMP: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mfpp_dp.sv -----
// Datapath: tick pacing, frame parser, sample store and output register.
`default_nettype none
module mfpp_dp #(
  parameter int STORE_BYTES = mfpp_pkg::STORE_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mfpp_pkg::cfg_t      cfg,
  input  mfpp_pkg::cmd_t      cmd,
  output mfpp_pkg::sts_t      sts,
  input  wire                 in_kind,
  input  wire  [7:0]          in_byte,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                out_dest,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  localparam int SAW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int SIW = $clog2(STORE_BYTES + 1);
  localparam logic [SIW-1:0] STORE_FULL = SIW'(STORE_BYTES);

  logic [7:0]     tick_r, pos_r, flen_r, sum_r;
  logic [SIW-1:0] sidx_r;
  logic [7:0]     store_r [STORE_BYTES];
  logic           ov_r, dest_r, last_r;
  logic [7:0]     obyte_r;

  logic           tick_due, in_data, is_check, store_wr;
  logic [7:0]     sum_add;

  assign tick_due = ({1'b0, tick_r} + 9'd1) >= {1'b0, cfg.period_ticks};
  assign sum_add  = sum_r + in_byte;
  assign in_data  = (pos_r >= mfpp_pkg::POS_DATA) && (pos_r < flen_r);
  assign is_check = (pos_r >= mfpp_pkg::POS_DATA) && (pos_r == flen_r);
  assign store_wr = in_data && !mfpp_pkg::is_skip(pos_r) && (sidx_r < STORE_FULL);

  assign sts.req_go   = !in_kind && tick_due;
  assign sts.dump_go  = in_kind && is_check && (sum_r == in_byte);
  assign sts.out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      pos_r  <= mfpp_pkg::POS_ACK;
      flen_r <= '0;
      sum_r  <= '0;
      sidx_r <= '0;
      for (int i = 0; i < STORE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else if (cmd.accept) begin
      if (!in_kind) begin
        if (tick_due) begin
          tick_r <= '0;
          pos_r  <= mfpp_pkg::POS_ACK;
          sum_r  <= '0;
          sidx_r <= '0;
        end else begin
          tick_r <= tick_r + 8'd1;
        end
      end else if (pos_r == mfpp_pkg::POS_ACK) begin
        if (in_byte == mfpp_pkg::ACK_BYTE) begin
          pos_r <= mfpp_pkg::POS_LEN;
          sum_r <= sum_add;
        end
      end else if (pos_r == mfpp_pkg::POS_LEN) begin
        flen_r <= in_byte;
        sum_r  <= sum_add;
        pos_r  <= mfpp_pkg::POS_DATA;
      end else if (in_data) begin
        if (store_wr) begin
          store_r[sidx_r[SAW-1:0]] <= in_byte;
          sidx_r                   <= sidx_r + 1'b1;
        end
        sum_r <= sum_add;
        pos_r <= pos_r + 8'd1;
      end else if (is_check) begin
        pos_r <= mfpp_pkg::POS_IDLE;
      end
    end
  end

  // output register: one byte a cycle while the sink keeps up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dest_r  <= cmd.sel_store;
      last_r  <= cmd.last;
      obyte_r <= cmd.sel_store ? store_r[cmd.idx[SAW-1:0]]
                               : mfpp_pkg::req_byte(cmd.idx[2:0], cfg);
    end
  end

  assign out_valid = ov_r;
  assign out_dest  = dest_r;
  assign out_byte  = obyte_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// ----- rtl/core/meter_frame_poll_and_parse.sv -----
// A result run starts once the controller leaves idle and the output register is loaded,
// then sends one byte per cycle while the sink holds out_tready high. An item with no
// result keeps in_tready high; a sending tick (8 request bytes) or a passing checksum
// byte (STORE_BYTES bytes) holds it low while the single output register takes its run.
// Reset: synchronous, active low; registers, parser and sample store return to defaults.
`default_nettype none
`include "meter_frame_poll_and_parse_assert.svh"
module meter_frame_poll_and_parse #(
  parameter int STORE_BYTES = mfpp_pkg::STORE_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire         in_tuser,    // [0] kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tuser,   // [0] dest
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mfpp_pkg::cfg_t cfg;
  mfpp_pkg::cmd_t cmd;
  mfpp_pkg::sts_t sts;

  mfpp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mfpp_ctrl #(.STORE_BYTES(STORE_BYTES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfpp_dp #(.STORE_BYTES(STORE_BYTES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dest  (out_tuser),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  `MFPP_ASSERT_ALWAYS(a_load_free, !cmd.load || sts.out_free, "load into a full output register")
  `MFPP_ASSERT_NEXT(a_req_busy, cmd.accept && sts.req_go, !in_tready, "request run not started")
  `MFPP_ASSERT_NEXT(a_run_end, cmd.load && cmd.last, in_tready, "controller stuck after run")

endmodule
`default_nettype wire

// ----- bench/meter_bench_pkg.sv -----
// Shared codes and the result record used by the meter poll/parse bench.
`timescale 1ns / 100ps
package meter_bench_pkg;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_RX     = 1'b1;
  localparam logic DEST_SENSOR = 1'b0;
  localparam logic DEST_SERVER = 1'b1;

  // {dest, byte, last}, matches {out_tuser, out_tdata, out_tlast}
  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } meter_byte_t;

endpackage

// ----- bench/meter_stream_checker.sv -----
// Watches the meter poll/parse channels, predicts the emitted bytes and compares them.
`timescale 1ns / 100ps
module meter_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          due_count
);

  localparam int STORE_N = mfpp_pkg::STORE_BYTES_DEF;

  logic [7:0] period_r, addr_r, len_r, req_sum_r;
  logic [7:0] tick_cnt, pos, flen, sum;
  int         fill;
  logic [7:0] sample_mem [0:STORE_N-1];

  meter_bench_pkg::meter_byte_t outgoing_bytes[$];

  function automatic logic dropped_pos(input logic [7:0] p);
    logic r;
    case (p)
      8'd4, 8'd5, 8'd6, 8'd11, 8'd12, 8'd23, 8'd24, 8'd25, 8'd26: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  task automatic poll_parse_step(input logic kind, input logic [7:0] rx);
    logic [7:0] req [0:7];
    int k;
    if (kind == meter_bench_pkg::KIND_TICK) begin
      if ({1'b0, tick_cnt} + 9'd1 < {1'b0, period_r}) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        tick_cnt = 8'd0;
        req = '{mfpp_pkg::HDR_BYTE, mfpp_pkg::FRAME_SIZE, mfpp_pkg::CMD_SET_PTR,
                mfpp_pkg::ADDR_HIGH, addr_r, mfpp_pkg::CMD_READ, len_r, req_sum_r};
        for (k = 0; k < 8; k++)
          outgoing_bytes.push_back({meter_bench_pkg::DEST_SENSOR, req[k], k == 7});
        pos = mfpp_pkg::POS_ACK;
        sum = 8'd0;
        fill = 0;
      end
    end else if (pos == mfpp_pkg::POS_IDLE) begin
      // parser done, wait for next poll
    end else if (pos == mfpp_pkg::POS_ACK) begin
      if (rx == mfpp_pkg::ACK_BYTE) begin
        pos = mfpp_pkg::POS_LEN;
        sum = sum + rx;
      end
    end else if (pos == mfpp_pkg::POS_LEN) begin
      flen = rx;
      sum = sum + rx;
      pos = mfpp_pkg::POS_DATA;
    end else if (pos < flen) begin
      if (!dropped_pos(pos) && fill < STORE_N) begin
        sample_mem[fill] = rx;
        fill++;
      end
      sum = sum + rx;
      pos = pos + 8'd1;
    end else if (pos == flen) begin
      pos = mfpp_pkg::POS_IDLE;
      if (sum == rx) begin
        for (k = 0; k < STORE_N; k++)
          outgoing_bytes.push_back({meter_bench_pkg::DEST_SERVER, sample_mem[k],
                                    k == STORE_N - 1});
      end
    end
    // frame length below 3 leaves pos past the end: bytes ignored
  endtask

  initial begin
    fail_count = 0;
    due_count = 0;
  end

  always @(posedge clk) begin
    meter_bench_pkg::meter_byte_t got, want;
    if (!rst_n) begin
      period_r = mfpp_pkg::PERIOD_RST;
      addr_r = mfpp_pkg::ADDR_RST;
      len_r = mfpp_pkg::LEN_RST;
      req_sum_r = mfpp_pkg::REQ_SUM_RST;
      tick_cnt = 8'd0;
      pos = mfpp_pkg::POS_ACK;
      flen = 8'd0;
      sum = 8'd0;
      fill = 0;
      for (int i = 0; i < STORE_N; i++) sample_mem[i] = 8'd0;
      outgoing_bytes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          mfpp_pkg::REG_PERIOD:  period_r = cfg_pwdata[7:0];
          mfpp_pkg::REG_ADDR:    addr_r = cfg_pwdata[7:0];
          mfpp_pkg::REG_LEN:     len_r = cfg_pwdata[7:0];
          mfpp_pkg::REG_REQ_SUM: req_sum_r = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        poll_parse_step(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata, out_tlast};
        if (outgoing_bytes.size() == 0) begin
          $display("%0t: out transfer expected none, got dest=%0d byte=%02h last=%0d",
                   $time, got.dest, got.data, got.last);
          fail_count++;
        end else begin
          want = outgoing_bytes.pop_front();
          if (got.dest !== want.dest || got.data !== want.data || got.last !== want.last) begin
            $display("%0t: out expected dest=%0d byte=%02h last=%0d, got dest=%0d byte=%02h last=%0d",
                     $time, want.dest, want.data, want.last, got.dest, got.data, got.last);
            fail_count++;
          end
        end
      end
    end
    due_count <= outgoing_bytes.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the meter poll/parse bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        in_tuser;    // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] out_byte
  logic        out_tuser;   // [0] dest
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  wire  [31:0] fail_count;
  wire  [31:0] due_count;

  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_phase = 1'b0;
  bit hold_done = 1'b0;

  meter_frame_poll_and_parse u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  meter_stream_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .due_count(due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("meter_frame_poll_and_parse: mismatch");
    $finish;
  end

  // sink side; one long hold-off on request so the block backs up into its input
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic put_item(input logic kind, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // drain all outstanding bytes, then give a dropped item time to finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == mfpp_pkg::ACK_BYTE) b = ~b;
    return b;
  endfunction

  // ticks enough for exactly one request, then a reply of random shape
  task automatic poll_and_reply(input int n_ticks);
    int style, flen, k;
    logic [7:0] csum, b;
    repeat (n_ticks) put_item(meter_bench_pkg::KIND_TICK, 8'($urandom_range(255)));
    repeat ($urandom_range(2)) put_item(meter_bench_pkg::KIND_RX, noise_byte());
    style = $urandom_range(99);
    if (style < 70) begin
      flen = ($urandom_range(7) == 0) ? $urandom_range(41, 64) : $urandom_range(3, 40);
      csum = mfpp_pkg::ACK_BYTE + flen[7:0];
      put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
      put_item(meter_bench_pkg::KIND_RX, flen[7:0]);
      for (k = 3; k < flen; k++) begin
        b = 8'($urandom_range(255));
        csum = csum + b;
        put_item(meter_bench_pkg::KIND_RX, b);
      end
      if ($urandom_range(99) < 85) put_item(meter_bench_pkg::KIND_RX, csum);
      else put_item(meter_bench_pkg::KIND_RX, csum + 8'($urandom_range(1, 255)));
      if ($urandom_range(2) == 0)
        put_item(meter_bench_pkg::KIND_RX, 8'($urandom_range(255)));
    end else if (style < 80) begin
      // short frame: length below the data start
      put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
      put_item(meter_bench_pkg::KIND_RX, 8'($urandom_range(2)));
      repeat ($urandom_range(1, 3))
        put_item(meter_bench_pkg::KIND_RX, 8'($urandom_range(255)));
    end else if (style < 90) begin
      // truncated frame, next poll restarts the parser
      flen = $urandom_range(8, 40);
      put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
      put_item(meter_bench_pkg::KIND_RX, flen[7:0]);
      repeat ($urandom_range(0, flen - 4))
        put_item(meter_bench_pkg::KIND_RX, 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6))
        put_item(meter_bench_pkg::KIND_RX, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input idle_mode_t mode, input logic [7:0] period,
                           input logic [7:0] addr, input logic [7:0] len,
                           input logic [7:0] rsum, input int n_frames, input bit with_hold);
    settle();
    gap_pct = 0;
    stall_pct = 0;
    cfg_write(mfpp_pkg::REG_PERIOD, period);
    cfg_write(mfpp_pkg::REG_ADDR, addr);
    cfg_write(mfpp_pkg::REG_LEN, len);
    cfg_write(mfpp_pkg::REG_REQ_SUM, rsum);
    case (mode)
      IDLE_SENDER:   gap_pct = 46;
      IDLE_RECEIVER: stall_pct = 46;
      IDLE_BOTH: begin
        gap_pct = 12;
        stall_pct = 12;
      end
      default: ;
    endcase
    if (with_hold) hold_phase = 1'b1;
    repeat (n_frames) poll_and_reply((period == 8'd0) ? 1 : period);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 4'd0;
    cfg_pwdata = 32'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: third tick polls
    put_item(meter_bench_pkg::KIND_TICK, 8'hFF);
    put_item(meter_bench_pkg::KIND_TICK, 8'h00);
    put_item(meter_bench_pkg::KIND_TICK, 8'h00);
    put_item(meter_bench_pkg::KIND_RX, 8'hFF);
    put_item(meter_bench_pkg::KIND_RX, 8'h00);
    put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
    put_item(meter_bench_pkg::KIND_RX, 8'd8);
    put_item(meter_bench_pkg::KIND_RX, 8'h80);
    put_item(meter_bench_pkg::KIND_RX, 8'h01);
    put_item(meter_bench_pkg::KIND_RX, 8'h02);
    put_item(meter_bench_pkg::KIND_RX, 8'h03);
    put_item(meter_bench_pkg::KIND_RX, 8'h7F);
    put_item(meter_bench_pkg::KIND_RX, 8'h13);
    put_item(meter_bench_pkg::KIND_RX, 8'hAA);   // parser idle after the check
    repeat (3) put_item(meter_bench_pkg::KIND_TICK, 8'h00);
    put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
    put_item(meter_bench_pkg::KIND_RX, 8'd0);    // short frame
    put_item(meter_bench_pkg::KIND_RX, 8'h55);
    put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
    repeat (3) put_item(meter_bench_pkg::KIND_TICK, 8'h00);
    put_item(meter_bench_pkg::KIND_RX, mfpp_pkg::ACK_BYTE);
    put_item(meter_bench_pkg::KIND_RX, 8'd3);    // checksum right after the length
    put_item(meter_bench_pkg::KIND_RX, 8'h09);

    run_phase(IDLE_NONE, 8'd1, 8'h00, 8'h00, 8'h00, 2, 1'b1);
    run_phase(IDLE_SENDER, 8'd0, 8'hFF, 8'hFF, 8'hFF, 2, 1'b0);
    run_phase(IDLE_RECEIVER, 8'd2, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 2, 1'b0);
    run_phase(IDLE_BOTH, 8'd5, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 2, 1'b0);
    run_phase(IDLE_NONE, 8'd40, 8'h55, 8'hAA, 8'h0F, 1, 1'b0);
    run_phase(IDLE_SENDER, 8'd3, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 2, 1'b0);
    run_phase(IDLE_RECEIVER, 8'd1, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 3, 1'b0);
    run_phase(IDLE_BOTH, 8'd2, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 3, 1'b0);

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("meter_frame_poll_and_parse: match");
    end else begin
      $display("meter_frame_poll_and_parse: mismatch");
    end
    $finish;
  end

endmodule
